### sv/text_console_writer_defines.svh
// Assertion macros for the text console writer; empty under synthesis.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TCW_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### sv/tcw_pkg.sv
// Shared types, constants and address helpers of the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int STORE_WORDS_DEF = 8192;
  localparam int LINE_CHARS_DEF  = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 13;
  localparam int DATA_W     = 16;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 48;

  localparam int WIDE_W     = 17;
  localparam int WRAP_STEPS = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] BLANK_WORD = 16'h0700;
  localparam logic [DATA_W-1:0] FILL_WORD  = 16'h0C00;
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h0B;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] read_addr;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Reduces a value below 4 * words into [0, words).
  function automatic logic [WIDE_W-1:0] wrap_addr(input logic [WIDE_W-1:0] a,
                                                  input logic [WIDE_W-1:0] words);
    logic [WIDE_W-1:0] v;
    int                i;
    v = a;
    for (i = 0; i < WRAP_STEPS; i++) begin
      if (v >= words) begin
        v = v - words;
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/tcw_front.sv
// Front end: accepts stream transactions and classifies them into commands.
`default_nettype none
module tcw_front (
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0] in_data_i,
  input  wire logic                           in_user_i,
  input  wire tcw_pkg::back_status_t          status_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output tcw_pkg::cmd_t                       q_data_o
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] ch;

  assign ch         = in_data_i[CHAR_W-1:0];
  assign in_ready_o = !q_full_i && !status_i.clearing;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_data_o.char_code = ch;
    q_data_o.read_addr = in_data_i[CHAR_W +: ADDR_W];
    if (in_user_i == CMD_READ) begin
      q_data_o.op = OP_READ;
    end else if (ch == CH_NEWLINE) begin
      q_data_o.op = OP_NEWLINE;
    end else if (ch == CH_RETURN) begin
      q_data_o.op = OP_RETURN;
    end else if (ch == CH_BACKSPACE) begin
      q_data_o.op = OP_BACKSPACE;
    end else begin
      q_data_o.op = OP_PUT;
    end
  end

endmodule
`default_nettype wire

### sv/tcw_queue.sv
// Short command queue between the front end and the execution engine.
`default_nettype none
`include "text_console_writer_defines.svh"
module tcw_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tcw_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output tcw_pkg::cmd_t      data_o,
  output logic               empty_o
);
  import tcw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;

  assign full_o  = (count_q == NW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + NW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  `TCW_ASSERT_NEVER(a_q_overflow, push_i && full_o && !pop_i, "queue overflow")
  `TCW_ASSERT_NEVER(a_q_underflow, pop_i && empty_o, "queue underflow")
  `TCW_ASSERT_NEVER(a_q_count, count_q > NW'(QUEUE_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

### sv/tcw_back.sv
// Execution engine: video store, cursor state, scroll sequencer, result register.
`default_nettype none
`include "text_console_writer_defines.svh"
module tcw_back #(
  parameter int STORE_WORDS = tcw_pkg::STORE_WORDS_DEF,
  parameter int LINE_CHARS  = tcw_pkg::LINE_CHARS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]      cfg_wdata_i,
  input  wire tcw_pkg::cmd_t                   cmd_i,
  input  wire logic                            cmd_valid_i,
  output logic                                 cmd_pop_o,
  output tcw_pkg::back_status_t                status_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]      out_data_o
);
  import tcw_pkg::*;

  localparam int AW           = $clog2(STORE_WORDS);
  localparam int CW           = $clog2(LINE_CHARS);
  localparam int RW           = $clog2(SCREEN_ROWS);
  localparam int SCREEN_WORDS = SCREEN_ROWS * LINE_CHARS;
  localparam int OW           = $clog2(SCREEN_WORDS);
  localparam int COPY_WORDS   = (SCREEN_ROWS - 1) * LINE_CHARS;
  localparam int CNT_MAX      = (STORE_WORDS > COPY_WORDS) ? STORE_WORDS : COPY_WORDS;
  localparam int CNTW         = $clog2(CNT_MAX);
  localparam int PAD_W        = OUT_TDATA_W - 2 * ADDR_W - DATA_W;

  localparam logic [WIDE_W-1:0] SW_W     = WIDE_W'(STORE_WORDS);
  localparam logic [WIDE_W-1:0] SW_M1_W  = WIDE_W'(STORE_WORDS - 1);
  localparam logic [WIDE_W-1:0] LC_W     = WIDE_W'(LINE_CHARS);
  localparam logic [WIDE_W-1:0] NEED_W   = WIDE_W'((SCREEN_ROWS + 1) * LINE_CHARS);
  localparam logic [WIDE_W-1:0] LAST_W   = WIDE_W'(COPY_WORDS);
  localparam logic [WIDE_W-1:0] SCREEN_W = WIDE_W'(SCREEN_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COPY,
    S_COPY_END,
    S_FILL,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]     origin_q, origin_d;
  logic [RW-1:0]     row_q, row_d;
  logic [OW-1:0]     rowoff_q, rowoff_d;
  logic [CW-1:0]     col_q, col_d;
  logic [CHAR_W-1:0] attr_q, attr_d;
  logic              is_read_q, is_read_d;
  logic              out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic [DATA_W-1:0] mem [STORE_WORDS];
  logic [DATA_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [CW-1:0]     col_eff;
  logic [WIDE_W-1:0] origin_w, cnt_w, cursor_w;
  logic [WIDE_W-1:0] rd_addr_w, src_w, dst_w, cnt_wrap_w, fill_w;
  logic              new_line, at_last_row, scroll_fits;
  logic [DATA_W-1:0] rd_result;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      if (mem_we && (mem_waddr == mem_raddr)) begin
        rd_q <= mem_wdata;
      end else begin
        rd_q <= mem[mem_raddr];
      end
    end
  end

  assign origin_w    = WIDE_W'(origin_q);
  assign cnt_w       = WIDE_W'(cnt_q);
  assign col_eff     = (state_q == S_IDLE && cmd_i.op == OP_BACKSPACE) ?
                       col_q - CW'(1) : col_q;
  assign cursor_w    = wrap_addr(origin_w + WIDE_W'(rowoff_q) + WIDE_W'(col_eff), SW_W);
  assign rd_addr_w   = wrap_addr(WIDE_W'(cmd_i.read_addr), SW_W);
  assign src_w       = wrap_addr(origin_w + LC_W + cnt_w, SW_W);
  assign dst_w       = wrap_addr(cnt_w - WIDE_W'(1), SW_W);
  assign cnt_wrap_w  = wrap_addr(cnt_w, SW_W);
  assign fill_w      = wrap_addr(origin_w + LAST_W + cnt_w, SW_W);
  assign at_last_row = (row_q == RW'(SCREEN_ROWS - 1));
  assign scroll_fits = (origin_w + NEED_W) <= SW_M1_W;
  assign rd_result   = is_read_q ? rd_q : '0;

  assign status_o.clearing = (state_q == S_CLEAR);
  assign out_valid_o       = out_vld_q;
  assign out_data_o        = out_data_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    origin_d   = origin_q;
    row_d      = row_q;
    rowoff_d   = rowoff_q;
    col_d      = col_q;
    attr_d     = cfg_we_i ? cfg_wdata_i : attr_q;
    is_read_d  = is_read_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_data_d = out_data_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = cursor_w[AW-1:0];
    mem_raddr  = rd_addr_w[AW-1:0];
    mem_wdata  = BLANK_WORD;
    new_line   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = (cnt_w < SCREEN_W) ? BLANK_WORD : '0;
        if (cnt_q == CNTW'(STORE_WORDS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_EMIT;
          case (cmd_i.op)
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = rd_addr_w[AW-1:0];
              is_read_d = 1'b1;
            end
            OP_NEWLINE: begin
              new_line = 1'b1;
            end
            OP_RETURN: begin
              col_d = '0;
            end
            OP_BACKSPACE: begin
              if (col_q != '0) begin
                col_d     = col_eff;
                mem_we    = 1'b1;
                mem_wdata = BLANK_WORD;
              end
            end
            default: begin
              mem_we    = 1'b1;
              mem_wdata = {attr_q, cmd_i.char_code};
              if (col_q == CW'(LINE_CHARS - 1)) begin
                col_d    = '0;
                new_line = 1'b1;
              end else begin
                col_d = col_q + CW'(1);
              end
            end
          endcase
          if (new_line) begin
            cnt_d = '0;
            if (!at_last_row) begin
              row_d    = row_q + RW'(1);
              rowoff_d = rowoff_q + OW'(LINE_CHARS);
            end else if (scroll_fits) begin
              origin_d = origin_q + AW'(LINE_CHARS);
              state_d  = S_FILL;
            end else begin
              state_d = S_COPY;
            end
          end
        end
      end
      S_COPY: begin
        mem_re    = 1'b1;
        mem_raddr = src_w[AW-1:0];
        mem_we    = (cnt_q != '0);
        mem_waddr = dst_w[AW-1:0];
        mem_wdata = rd_q;
        if (cnt_q == CNTW'(COPY_WORDS - 1)) begin
          state_d = S_COPY_END;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_COPY_END: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_wrap_w[AW-1:0];
        mem_wdata = rd_q;
        origin_d  = '0;
        cnt_d     = '0;
        state_d   = S_FILL;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_w[AW-1:0];
        mem_wdata = FILL_WORD;
        if (cnt_q == CNTW'(LINE_CHARS - 1)) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = {PAD_W'(0), rd_result, origin_w[ADDR_W-1:0], cursor_w[ADDR_W-1:0]};
          is_read_d  = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      origin_q  <= '0;
      row_q     <= '0;
      rowoff_q  <= '0;
      col_q     <= '0;
      attr_q    <= ATTR_RESET;
      is_read_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      origin_q  <= origin_d;
      row_q     <= row_d;
      rowoff_q  <= rowoff_d;
      col_q     <= col_d;
      attr_q    <= attr_d;
      is_read_q <= is_read_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  `TCW_ASSERT(a_rowoff, rowoff_q == OW'(row_q * LINE_CHARS), "row offset out of step with row")
  `TCW_ASSERT(a_emit_src, $rose(out_vld_q) |-> $past(state_q == S_EMIT), "result outside emit")
  `TCW_ASSERT_NEVER(a_clear_pop, (state_q == S_CLEAR) && cmd_pop_o, "command taken while clearing")

endmodule
`default_nettype wire

### sv/text_console_writer.sv
// Top level of the text console writer: front end, command queue, execution engine.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata char_code, read_addr; tuser command
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata cursor_addr, origin_addr, read_data
//   cfg       in   cfg_we_i                       cfg_wdata_i text_attribute
//
// In the engine, put, newline, return, backspace and read pass through the idle state, then the emit state.
// Scroll with origin advance adds a fill of LINE_CHARS words; scroll with copy first copies
// (SCREEN_ROWS-1)*LINE_CHARS words, then fills LINE_CHARS words (one store port).
// After reset every store word is initialized, one at a time; s_axis_tready is low then.
// A two-entry queue keeps accepting, until it is full, while the engine is busy or the result waits.
`default_nettype none
module text_console_writer #(
  parameter int STORE_WORDS = tcw_pkg::STORE_WORDS_DEF,
  parameter int LINE_CHARS  = tcw_pkg::LINE_CHARS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [7:0] char_code, [20:8] read_addr, [23:21] zero
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] command
  input  wire logic [0:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [12:0] cursor_addr, [25:13] origin_addr, [41:26] read_data, [47:42] zero
  output logic [tcw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       cfg_wdata_i
);
  import tcw_pkg::*;

  back_status_t status;
  cmd_t         push_data, pop_data;
  logic         push, pop, q_full, q_empty;

  tcw_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser[0]),
    .status_i   (status),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (q_empty)
  );

  tcw_back #(
    .STORE_WORDS (STORE_WORDS),
    .LINE_CHARS  (LINE_CHARS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (pop_data),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (pop),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
